// ===== rtl/rtcts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the RTC snapshot to timestamp unit.
// Depends on nothing; used by the channel interfaces and the top level.
package rtcts_pkg;

    // Input word: one raw snapshot of the clock bytes
    typedef struct packed {
        logic       start_req;
        logic       update_busy;
        logic [7:0] seconds_raw;
        logic [7:0] minutes_raw;
        logic [7:0] hours_raw;
        logic [7:0] day_raw;
        logic [7:0] month_raw;
        logic [7:0] year_raw;
        logic [7:0] century_raw;
        logic [7:0] format_raw;
    } snap_t;

    // Output word: decoded fields and Unix seconds
    typedef struct packed {
        logic signed [40:0] timestamp;
        logic [14:0]        full_year;
        logic [7:0]         month_out;
        logic [7:0]         day_out;
        logic [7:0]         hour_out;
        logic [7:0]         minute_out;
        logic [7:0]         second_out;
        logic               calendar_bad;
    } stamp_t;

    // Configuration register indexes
    typedef enum logic {
        REG_CENTURY   = 1'b0,
        REG_BASE_YEAR = 1'b1
    } reg_idx_t;

    // Format byte bits
    localparam int unsigned FMT_BINARY_BIT = 2;
    localparam int unsigned FMT_24H_BIT    = 1;

    localparam logic [13:0] BASE_YEAR_RESET = 14'd2026;

    // Multiplier constants; floor(x/100) = (x*5243) >> 19 for x below 2**15
    localparam logic signed [17:0] RECIP_100     = 18'sd5243;
    localparam int unsigned        RECIP_SHIFT   = 19;
    localparam logic signed [17:0] MUL_100       = 18'sd100;
    localparam logic signed [17:0] MUL_NEG_100   = -18'sd100;
    localparam logic signed [17:0] DAYS_PER_YEAR = 18'sd365;
    localparam logic signed [17:0] MUL_60        = 18'sd60;
    localparam logic signed [17:0] SEC_PER_DAY   = 18'sd86400;

    // Offset from the shifted proleptic day count to days since 1970-01-01
    localparam logic signed [41:0] DAYS_BIAS = 42'sd865566;

    // Packed BCD to binary, nibbles taken as they are
    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Hour BCD decode: three-bit tens digit, PM flag carried through
    function automatic logic [7:0] hour_bcd_to_bin(input logic [7:0] v);
        logic [6:0] hi;
        hi = {4'd0, v[6:4]};
        return {v[7], (hi << 3) + (hi << 1) + {3'd0, v[3:0]}};
    endfunction

    // Remainder by 24 for values below 144
    function automatic logic [7:0] mod24(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        for (int i = 0; i < 5; i++)
        begin
            if (r >= 8'd24)
                r = r - 8'd24;
        end
        return r;
    endfunction

    // Days in month; zero for a month outside 1..12
    function automatic logic [4:0] month_len(input logic [7:0] mon, input logic leap);
        logic [4:0] n;
        unique case (mon)
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: n = 5'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                   n = 5'd30;
            8'd2:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd0;
        endcase
        return n;
    endfunction

    // Day offset of the first of a month in a year that starts in March
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] d;
        unique case (mon)
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/rtcts_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for snapshot words and timestamp words.
// Depends on rtcts_pkg for the payload types.

interface rtcts_in_if;
    logic                 valid;
    logic                 ready;
    rtcts_pkg::snap_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtcts_out_if;
    logic                 valid;
    logic                 ready;
    rtcts_pkg::stamp_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rtc_snapshot_to_timestamp_unit.sv =====
`timescale 1ns / 1ps
// RTC snapshot to Unix timestamp converter: snapshot matching, BCD decode, calendar check.
// Depends on rtcts_pkg and the channel interfaces in rtcts_if.sv.
//
//  Port    | Kind          | Word
//  --------+---------------+-----------------------------------------------
//  snap    | valid/ready in | raw clock bytes, start and busy flags
//  stamp   | valid/ready out| Unix seconds, full year, decoded fields, flag
//  APB     | register port | century_present at 0x0, base_year at 0x4
//
// A snapshot that is dropped or only stored ends in the accept step. A snapshot
// that matches the stored one takes the accept step plus 12 sequencer steps, and
// jumps from the check to done when the calendar check fails; the arithmetic
// steps share one 26x18 multiply-add unit. The result sits in an output
// register, so the next snapshot is taken while it waits; the sequencer stalls
// in its last step only when a second result is ready before the first is taken.
// Reset clears the stored snapshot, century_present and the output, and sets base_year to 2026.

module rtc_snapshot_to_timestamp_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    rtcts_in_if.sink            snap,
    rtcts_out_if.source         stamp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CENTURY,
        ST_YEAR,
        ST_LEAP_DIV,
        ST_LEAP_REM,
        ST_CHECK,
        ST_CIVIL_DIV,
        ST_CIVIL_DAYS,
        ST_CLOCK_HM,
        ST_CLOCK_HMS,
        ST_STAMP,
        ST_DONE
    } state_t;

    // Control and configuration
    state_t              state_reg, state_next;
    logic                cp_reg, cp_next;
    logic [13:0]         base_reg, base_next;
    logic [55:0]         prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic                out_valid_reg, out_valid_next;
    rtcts_pkg::stamp_t   out_data_reg, out_data_next;

    // Working registers
    logic                fmt_bin_reg, fmt_bin_next;
    logic                fmt_24h_reg, fmt_24h_next;
    logic [7:0]          sec_reg, sec_next;
    logic [7:0]          min_reg, min_next;
    logic [7:0]          hour_reg, hour_next;
    logic [7:0]          day_reg, day_next;
    logic [7:0]          mon_reg, mon_next;
    logic [7:0]          year8_reg, year8_next;
    logic [14:0]         full_year_reg, full_year_next;
    logic [8:0]          qy_reg, qy_next;
    logic                bad_reg, bad_next;
    logic [14:0]         y2_reg, y2_next;
    logic [8:0]          day_off_reg, day_off_next;
    logic signed [24:0]  days_reg, days_next;
    logic signed [41:0]  acc_reg, acc_next;

    // Shared multiply-add unit
    logic signed [25:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [41:0]  mul_c;
    logic signed [43:0]  mul_prod;
    logic signed [43:0]  mul_sum;

    // Combinational helpers
    logic                snap_fire;
    logic                have_eff;
    logic [7:0]          cent_eff;
    logic [55:0]         snap_word;
    logic [7:0]          hour_dec;
    logic [7:0]          hour_fix;
    logic [14:0]         fy_sum;
    logic [6:0]          year_rem;
    logic                leap;
    logic [4:0]          mlen;
    logic                bad_now;
    logic [8:0]          q2;
    logic signed [41:0]  civil_off;
    logic                cfg_write;

    // Multiply-add: one product and one add per cycle
    assign mul_prod = mul_a * mul_b;
    assign mul_sum  = mul_prod + 44'(mul_c);

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    always_comb
    begin
        unique case (rtcts_pkg::reg_idx_t'(paddr[2]))
            rtcts_pkg::REG_CENTURY:   prdata = {31'd0, cp_reg};
            rtcts_pkg::REG_BASE_YEAR: prdata = {18'd0, base_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Snapshot capture
    assign snap.ready = (state_reg == ST_IDLE);
    assign snap_fire  = snap.valid && snap.ready;
    assign have_eff   = have_prev_reg && !snap.payload.start_req;
    assign cent_eff   = cp_reg ? snap.payload.century_raw : 8'd0;
    assign snap_word  = {cent_eff, snap.payload.year_raw, snap.payload.month_raw,
                         snap.payload.day_raw, snap.payload.hours_raw,
                         snap.payload.minutes_raw, snap.payload.seconds_raw};

    // Hour decode and 12-hour to 24-hour fold
    assign hour_dec = fmt_bin_reg ? prev_reg[23:16]
                                  : rtcts_pkg::hour_bcd_to_bin(prev_reg[23:16]);
    assign hour_fix = (!fmt_24h_reg && hour_dec[7])
                    ? rtcts_pkg::mod24({1'b0, hour_dec[6:0]} + 8'd12) : hour_dec;

    // Year after century, with rollover past the base year
    assign fy_sum = acc_reg[14:0];

    // Leap rule and calendar range check
    assign year_rem = acc_reg[6:0];
    assign leap     = ((full_year_reg[1:0] == 2'd0) && (year_rem != 7'd0))
                   || ((year_rem == 7'd0) && (qy_reg[1:0] == 2'd0));
    assign mlen     = rtcts_pkg::month_len(mon_reg, leap);
    assign bad_now  = (mlen == 5'd0) || (day_reg == 8'd0) || (day_reg > {3'd0, mlen})
                   || (hour_reg > 8'd23) || (min_reg > 8'd59) || (sec_reg > 8'd59);

    // Day count terms besides 365 per year
    assign q2        = acc_reg[27:19];
    assign civil_off = $signed(42'(y2_reg[14:2])) - $signed(42'(q2))
                     + $signed(42'(q2[8:2])) + $signed(42'(day_off_reg)) - rtcts_pkg::DAYS_BIAS;

    // Next-state and datapath sequencing
    always_comb
    begin
        state_next     = state_reg;
        cp_next        = cp_reg;
        base_next      = base_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        fmt_bin_next   = fmt_bin_reg;
        fmt_24h_next   = fmt_24h_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        mon_next       = mon_reg;
        year8_next     = year8_reg;
        full_year_next = full_year_reg;
        qy_next        = qy_reg;
        bad_next       = bad_reg;
        y2_next        = y2_reg;
        day_off_next   = day_off_reg;
        days_next      = days_reg;
        acc_next       = acc_reg;
        mul_a          = 26'sd0;
        mul_b          = 18'sd0;
        mul_c          = 42'sd0;

        // Write configuration
        if (cfg_write)
        begin
            unique case (rtcts_pkg::reg_idx_t'(paddr[2]))
                rtcts_pkg::REG_CENTURY:   cp_next   = pwdata[0];
                rtcts_pkg::REG_BASE_YEAR: base_next = pwdata[13:0];
                default:                  cp_next   = cp_reg;
            endcase
        end

        // Drop the output word once taken
        if (out_valid_reg && stamp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (snap_fire)
                begin
                    have_prev_next = have_eff;
                    if (!snap.payload.update_busy)
                    begin
                        if (have_eff && (snap_word == prev_reg))
                        begin
                            fmt_bin_next = snap.payload.format_raw[rtcts_pkg::FMT_BINARY_BIT];
                            fmt_24h_next = snap.payload.format_raw[rtcts_pkg::FMT_24H_BIT];
                            state_next   = ST_DECODE;
                        end
                        else
                        begin
                            prev_next      = snap_word;
                            have_prev_next = 1'b1;
                        end
                    end
                end
            end
            ST_DECODE:
            begin
                sec_next   = fmt_bin_reg ? prev_reg[7:0]   : rtcts_pkg::bcd_dec(prev_reg[7:0]);
                min_next   = fmt_bin_reg ? prev_reg[15:8]  : rtcts_pkg::bcd_dec(prev_reg[15:8]);
                hour_next  = hour_fix;
                day_next   = fmt_bin_reg ? prev_reg[31:24] : rtcts_pkg::bcd_dec(prev_reg[31:24]);
                mon_next   = fmt_bin_reg ? prev_reg[39:32] : rtcts_pkg::bcd_dec(prev_reg[39:32]);
                year8_next = fmt_bin_reg ? prev_reg[47:40] : rtcts_pkg::bcd_dec(prev_reg[47:40]);
                // base_year / 100 by reciprocal
                mul_a      = $signed(26'(base_reg));
                mul_b      = rtcts_pkg::RECIP_100;
                acc_next   = mul_sum[41:0];
                state_next = ST_CENTURY;
            end
            ST_CENTURY:
            begin
                mul_a      = cp_reg ? $signed(26'(prev_reg[55:48]))
                                    : $signed(26'(acc_reg[26:rtcts_pkg::RECIP_SHIFT]));
                mul_b      = rtcts_pkg::MUL_100;
                mul_c      = $signed(42'(year8_reg));
                acc_next   = mul_sum[41:0];
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (!cp_reg && (fy_sum < {1'b0, base_reg}))
                    full_year_next = fy_sum + 15'd100;
                else
                    full_year_next = fy_sum;
                state_next = ST_LEAP_DIV;
            end
            ST_LEAP_DIV:
            begin
                mul_a      = $signed(26'(full_year_reg));
                mul_b      = rtcts_pkg::RECIP_100;
                acc_next   = mul_sum[41:0];
                state_next = ST_LEAP_REM;
            end
            ST_LEAP_REM:
            begin
                qy_next    = acc_reg[27:19];
                mul_a      = $signed(26'(acc_reg[27:19]));
                mul_b      = rtcts_pkg::MUL_NEG_100;
                mul_c      = $signed(42'(full_year_reg));
                acc_next   = mul_sum[41:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                bad_next     = bad_now;
                y2_next      = full_year_reg + 15'd400 - {14'd0, (mon_reg <= 8'd2)};
                day_off_next = rtcts_pkg::month_start(mon_reg[3:0]) + {1'b0, day_reg};
                state_next   = bad_now ? ST_DONE : ST_CIVIL_DIV;
            end
            ST_CIVIL_DIV:
            begin
                mul_a      = $signed(26'(y2_reg));
                mul_b      = rtcts_pkg::RECIP_100;
                acc_next   = mul_sum[41:0];
                state_next = ST_CIVIL_DAYS;
            end
            ST_CIVIL_DAYS:
            begin
                mul_a      = $signed(26'(y2_reg));
                mul_b      = rtcts_pkg::DAYS_PER_YEAR;
                mul_c      = civil_off;
                acc_next   = mul_sum[41:0];
                state_next = ST_CLOCK_HM;
            end
            ST_CLOCK_HM:
            begin
                days_next  = acc_reg[24:0];
                mul_a      = $signed(26'(hour_reg));
                mul_b      = rtcts_pkg::MUL_60;
                mul_c      = $signed(42'(min_reg));
                acc_next   = mul_sum[41:0];
                state_next = ST_CLOCK_HMS;
            end
            ST_CLOCK_HMS:
            begin
                mul_a      = acc_reg[25:0];
                mul_b      = rtcts_pkg::MUL_60;
                mul_c      = $signed(42'(sec_reg));
                acc_next   = mul_sum[41:0];
                state_next = ST_STAMP;
            end
            ST_STAMP:
            begin
                mul_a      = 26'(days_reg);
                mul_b      = rtcts_pkg::SEC_PER_DAY;
                mul_c      = acc_reg;
                acc_next   = mul_sum[41:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || stamp.ready)
                begin
                    out_data_next.timestamp    = bad_reg ? 41'sd0 : acc_reg[40:0];
                    out_data_next.full_year    = full_year_reg;
                    out_data_next.month_out    = mon_reg;
                    out_data_next.day_out      = day_reg;
                    out_data_next.hour_out     = hour_reg;
                    out_data_next.minute_out   = min_reg;
                    out_data_next.second_out   = sec_reg;
                    out_data_next.calendar_bad = bad_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cp_reg        <= 1'b0;
            base_reg      <= rtcts_pkg::BASE_YEAR_RESET;
            prev_reg      <= 56'd0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            fmt_bin_reg   <= 1'b0;
            fmt_24h_reg   <= 1'b0;
            sec_reg       <= 8'd0;
            min_reg       <= 8'd0;
            hour_reg      <= 8'd0;
            day_reg       <= 8'd0;
            mon_reg       <= 8'd0;
            year8_reg     <= 8'd0;
            full_year_reg <= 15'd0;
            qy_reg        <= 9'd0;
            bad_reg       <= 1'b0;
            y2_reg        <= 15'd0;
            day_off_reg   <= 9'd0;
            days_reg      <= 25'sd0;
            acc_reg       <= 42'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            cp_reg        <= cp_next;
            base_reg      <= base_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            fmt_bin_reg   <= fmt_bin_next;
            fmt_24h_reg   <= fmt_24h_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            mon_reg       <= mon_next;
            year8_reg     <= year8_next;
            full_year_reg <= full_year_next;
            qy_reg        <= qy_next;
            bad_reg       <= bad_next;
            y2_reg        <= y2_next;
            day_off_reg   <= day_off_next;
            days_reg      <= days_next;
            acc_reg       <= acc_next;
        end
    end

    // Drive the output channel
    assign stamp.valid   = out_valid_reg;
    assign stamp.payload = out_data_reg;

endmodule
